// File: rtl/core/salloc_pkg.sv
package salloc_pkg;

    // Pool size. The width of the response slot field fixes it.
    localparam int SLOT_COUNT = 512;
    localparam int SLOT_W     = 9;
    localparam int SLOT_IN_W  = 10;
    localparam int CNT_W      = 10;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [SLOT_IN_W-1:0] slot_in;
    } salloc_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              ok;
        logic              can_allocate;
    } salloc_rsp_t;

endpackage

// File: rtl/core/slot_allocator_free_stack.sv
// Slot allocator built from a free stack in front of a bump counter.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and each
// one produces exactly one response on the rsp channel (rsp_valid,
// rsp_stall, rsp). A transfer happens on a rising edge where valid is high
// and stall is low. An allocate returns the most recently released slot,
// or the next never-used slot when the free stack is empty. A release of an
// in-use slot pushes it back on the stack; any other release is refused.
//
// A request transfer loads the input register and the decision then loads
// the response register; without stalls one request is taken every cycle.
// The request transfer edge reads the in-use bitmap at the request's slot;
// the next cycle makes the decision and the following edge loads the
// response register. When the receiver stalls, the response register holds;
// one more request may then sit in the input register, and after that
// req_stall rises until the response moves on.
//
// After reset the pool is empty of allocations and the free stack is empty.
// The in-use bitmap needs no clearing pass: a slot at or above the bump
// counter has never been handed out, so its bit reads as clear regardless
// of what the memory holds. Requests are accepted right after reset.
module slot_allocator_free_stack (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  salloc_pkg::salloc_req_t  req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output salloc_pkg::salloc_rsp_t  rsp
);
    import salloc_pkg::*;

    // Input stage.
    logic        in_full_reg;
    salloc_req_t req_reg;

    // In-use bitmap with a registered read and a one-deep forward of the
    // write that landed on the same edge as the read.
    logic bit_mem [SLOT_COUNT];
    logic bit_rd_reg;
    logic hit_reg;
    logic hit_val_reg;

    // Free stack. The top entry lives in top_reg; the memory holds the
    // entries below it. The entry just under the top is prefetched every
    // cycle into sec_rd_reg, and a push bypasses the memory via byp_reg.
    logic [SLOT_W-1:0] stack_mem [SLOT_COUNT];
    logic [SLOT_W-1:0] top_reg;
    logic [SLOT_W-1:0] top_next;
    logic [SLOT_W-1:0] sec_rd_reg;
    logic              byp_reg;
    logic [SLOT_W-1:0] byp_val_reg;
    logic [SLOT_W-1:0] sec;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] bump_reg;
    logic [CNT_W-1:0] bump_next;

    // Output register.
    logic        out_valid_reg;
    salloc_rsp_t rsp_reg;
    salloc_rsp_t rsp_next;

    logic              advance;
    logic              accept;
    logic              in_use;
    logic              push;
    logic              bit_we;
    logic [SLOT_W-1:0] bit_wa;
    logic              bit_wd;
    logic [SLOT_W-1:0] stk_wa;
    logic [SLOT_W-1:0] stk_ra;
    logic [SLOT_W-1:0] rd_slot;

    // The decision stage moves when the response register is free or is
    // being emptied in this cycle.
    assign advance   = in_full_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_full_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rd_slot   = req.slot_in[SLOT_W-1:0];

    // A slot at or above the bump counter was never allocated.
    assign in_use = (req_reg.slot_in < bump_reg)
                  ? (hit_reg ? hit_val_reg : bit_rd_reg) : 1'b0;
    assign sec    = byp_reg ? byp_val_reg : sec_rd_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        bump_next = bump_reg;
        top_next  = top_reg;
        push      = 1'b0;
        bit_we    = 1'b0;
        bit_wa    = req_reg.slot_in[SLOT_W-1:0];
        bit_wd    = 1'b0;
        rsp_next  = '0;
        if (advance)
        begin
            if (req_reg.req_type == REQ_ALLOC)
            begin
                if (cnt_reg != '0)
                begin
                    // Pop the most recently released slot.
                    rsp_next.slot_out = top_reg;
                    rsp_next.ok       = 1'b1;
                    top_next          = sec;
                    cnt_next          = cnt_reg - 1'b1;
                    bit_we            = 1'b1;
                    bit_wa            = top_reg;
                    bit_wd            = 1'b1;
                end
                else if (bump_reg < CNT_W'(SLOT_COUNT))
                begin
                    rsp_next.slot_out = bump_reg[SLOT_W-1:0];
                    rsp_next.ok       = 1'b1;
                    bump_next         = bump_reg + 1'b1;
                    bit_we            = 1'b1;
                    bit_wa            = bump_reg[SLOT_W-1:0];
                    bit_wd            = 1'b1;
                end
            end
            else if (req_reg.slot_in < CNT_W'(SLOT_COUNT) && in_use &&
                     cnt_reg < CNT_W'(SLOT_COUNT))
            begin
                rsp_next.slot_out = req_reg.slot_in[SLOT_W-1:0];
                rsp_next.ok       = 1'b1;
                push              = 1'b1;
                top_next          = req_reg.slot_in[SLOT_W-1:0];
                cnt_next          = cnt_reg + 1'b1;
                bit_we            = 1'b1;
                bit_wd            = 1'b0;
            end
        end
        rsp_next.can_allocate = (cnt_next != '0) || (bump_next < CNT_W'(SLOT_COUNT));
    end

    // On a push the old top goes into the memory just below the new top.
    assign stk_wa = SLOT_W'(cnt_reg - 1'b1);
    // Prefetch the entry under the top as it will stand after this edge.
    assign stk_ra = SLOT_W'(cnt_next - 2'd2);

    always_ff @(posedge clk)
    begin
        if (bit_we)
        begin
            bit_mem[bit_wa] <= bit_wd;
        end
        if (accept)
        begin
            bit_rd_reg  <= bit_mem[rd_slot];
            hit_reg     <= bit_we && (bit_wa == rd_slot);
            hit_val_reg <= bit_wd;
            req_reg     <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && cnt_reg != '0)
        begin
            stack_mem[stk_wa] <= top_reg;
        end
        sec_rd_reg <= stack_mem[stk_ra];
        if (push)
        begin
            byp_val_reg <= top_reg;
        end
        top_reg <= top_next;
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
            cnt_reg       <= '0;
            bump_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            if (!out_valid_reg || !rsp_stall)
            begin
                out_valid_reg <= advance;
            end
            if (advance)
            begin
                byp_reg <= push;
            end
            cnt_reg  <= cnt_next;
            bump_reg <= bump_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // A refused request leaves the stack depth and the bump counter alone.
    a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !rsp_next.ok |=>
            cnt_reg == $past(cnt_reg) && bump_reg == $past(bump_reg))
        else $error("refused request changed allocator state");

    // A fresh slot is granted only from an empty free stack and bumps the counter.
    a_bump_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rsp_next.ok && req_reg.req_type == REQ_ALLOC && cnt_reg == '0 |=>
            bump_reg == $past(bump_reg) + 1'b1)
        else $error("bump counter did not advance on fresh grant");

    // A failed response always carries slot zero.
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.slot_out == '0)
        else $error("failed response carries a nonzero slot");

    // The stack never holds more entries than the bump counter has handed out.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bump_reg)
        else $error("free stack deeper than slots ever handed out");

endmodule
